[rtl/per_file_write_coalescer_top_macros.svh]
// Assertion macros for the per-file write coalescer.
`ifndef PER_FILE_WRITE_COALESCER_TOP_MACROS_SVH
`define PER_FILE_WRITE_COALESCER_TOP_MACROS_SVH

// Checked outside reset only.
`define PFWC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pfwc assertion failed");

// Checked at every edge, reset included.
`define PFWC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("pfwc assertion failed");

`endif

[rtl/pfwc_pkg.sv]
// Shared types, codes and helpers of the per-file write coalescer.
`default_nettype none

package pfwc_pkg;

  localparam int NUM_FILES = 1024;
  localparam int IDX_W     = $clog2(NUM_FILES);

  localparam int KIND_W = 4;
  localparam int SLOT_W = 10;
  localparam int AMT_W  = 31;
  localparam int POS_W  = 48;
  localparam int TYPE_W = 3;
  localparam int STAT_W = 2;
  localparam int LAZ_W  = 2;

  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] BATCH_LIMIT_RST = 48'd1048576;

  // configuration port
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 64;
  localparam int REG_IDX_BIT = PADDR_W - 1;
  localparam logic REG_BATCH_LIMIT   = 1'b0;
  localparam logic REG_SYNC_LAZINESS = 1'b1;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_OPEN   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_PWRITE = 4'd3;
  localparam logic [KIND_W-1:0] KIND_SEEK   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_FSYNC  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_FDSYNC = 4'd6;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 4'd8;

  // result item types
  localparam logic [TYPE_W-1:0] ITEM_STATUS = 3'd0;
  localparam logic [TYPE_W-1:0] ITEM_BATCH  = 3'd1;
  localparam logic [TYPE_W-1:0] ITEM_FSYNC  = 3'd2;
  localparam logic [TYPE_W-1:0] ITEM_FDSYNC = 3'd3;
  localparam logic [TYPE_W-1:0] ITEM_CLOSE  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNTRACKED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OCCUPIED  = 2'd2;

  // sync laziness levels
  localparam logic [LAZ_W-1:0] LAZ_EAGER  = 2'd0;
  localparam logic [LAZ_W-1:0] LAZ_WAIT   = 2'd1;
  localparam logic [LAZ_W-1:0] LAZ_NOWAIT = 2'd2;
  localparam logic [LAZ_W-1:0] LAZ_IGNORE = 2'd3;

  // command queue and result queue sizing
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int RES_MAX    = 3;
  localparam int RES_BCNT_W = $clog2(RES_MAX + 1);
  localparam int RES_DEPTH  = 4;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

  typedef enum logic [3:0] {
    OP_OPEN,
    OP_READ,
    OP_WRITE,
    OP_PWRITE,
    OP_SEEK,
    OP_FSYNC,
    OP_FDSYNC,
    OP_CLOSE,
    OP_QUERY,
    OP_UNTRACKED
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [AMT_W-1:0] amount;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] initial_size;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] cur_pos;
    logic [POS_W-1:0] size;
    logic [POS_W-1:0] bstart;
    logic [POS_W-1:0] bbytes;
    logic             sync_def;
    logic             dsync_def;
  } entry_t;

  typedef struct packed {
    logic [TYPE_W-1:0] item_type;
    logic [POS_W-1:0]  batch_offset;
    logic [POS_W-1:0]  batch_length;
    logic              data_only;
    logic              wait_for_done;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  file_size;
    logic              last;
  } res_t;

  typedef struct packed {
    logic                  push;
    logic [RES_BCNT_W-1:0] cnt;
    res_t [RES_MAX-1:0]    res;
  } res_batch_t;

  typedef struct packed {
    logic [POS_W-1:0] batch_limit;
    logic [LAZ_W-1:0] sync_laziness;
  } cfg_t;

  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_W] ? POS_MAX : s[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/pfwc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfwc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/pfwc_front.sv]
// Front end: accepts items, classifies kind and slot, queues commands.
`default_nettype none

module pfwc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [pfwc_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [pfwc_pkg::SLOT_W-1:0]   file_slot_i,
  input  wire logic [pfwc_pkg::AMT_W-1:0]    amount_i,
  input  wire logic [pfwc_pkg::POS_W-1:0]    position_i,
  input  wire logic [pfwc_pkg::POS_W-1:0]    initial_size_i,
  input  wire logic                          hold_i,
  output logic                               cmd_valid_o,
  output pfwc_pkg::cmd_t                     cmd_o,
  input  wire logic                          cmd_pop_i
);
  import pfwc_pkg::*;

  cmd_t                  q_mem_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  cmd_t                  cmd_d;
  op_e                   op;
  logic                  in_range;
  logic                  push;

  always_comb begin
    unique case (kind_i)
      KIND_OPEN:   op = OP_OPEN;
      KIND_READ:   op = OP_READ;
      KIND_WRITE:  op = OP_WRITE;
      KIND_PWRITE: op = OP_PWRITE;
      KIND_SEEK:   op = OP_SEEK;
      KIND_FSYNC:  op = OP_FSYNC;
      KIND_FDSYNC: op = OP_FDSYNC;
      KIND_CLOSE:  op = OP_CLOSE;
      default:     op = OP_QUERY;
    endcase
    in_range = 32'(file_slot_i) < 32'(NUM_FILES);
    cmd_d.op           = in_range ? op : OP_UNTRACKED;
    cmd_d.idx          = IDX_W'(file_slot_i);
    cmd_d.amount       = amount_i;
    cmd_d.position     = position_i;
    cmd_d.initial_size = initial_size_i;
  end

  assign in_ready_o  = (cnt_q != CMDQ_CNT_W'(CMDQ_DEPTH)) && !hold_i;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CMDQ_CNT_W'(push) - CMDQ_CNT_W'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_d;
    end
  end

endmodule

`default_nettype wire

[rtl/pfwc_back.sv]
// Back end: file table read-modify-write and result generation.
`default_nettype none

module pfwc_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pfwc_pkg::cfg_t        cfg_i,
  input  wire logic                  cmd_valid_i,
  input  wire pfwc_pkg::cmd_t        cmd_i,
  output logic                       cmd_pop_o,
  output logic                       clearing_o,
  input  wire logic                  res_space_i,
  output pfwc_pkg::res_batch_t       res_o
);
  import pfwc_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam int ENT_W = $bits(entry_t);

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  cmd_t             cur_q;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;
  entry_t           ent, ent_new;
  logic             fire;

  logic [POS_W-1:0] lim, amt, at, end_pos, bb_ext, bs_new, bb_sum;
  logic             contig, hit, has_bb;
  logic             a_vld, b_vld;
  res_t             a_res, b_res, s_res;

  pfwc_ram #(
    .Width (ENT_W),
    .Depth (NUM_FILES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cmd_i.idx),
    .rdata_o (ram_rdata)
  );

  assign ent        = entry_t'(ram_rdata);
  assign clearing_o = state_q == ST_CLEAR;

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cur_q.idx;
    ram_wdata = ENT_W'(ent_new);
    cmd_pop_o = 1'b0;
    fire      = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == IDX_W'(NUM_FILES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          ram_re    = 1'b1;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (res_space_i) begin
          fire    = 1'b1;
          ram_we  = cur_q.op != OP_UNTRACKED;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // entry update
  always_comb begin
    lim     = (cfg_i.batch_limit == '0) ? POS_W'(1) : cfg_i.batch_limit;
    amt     = POS_W'(cur_q.amount);
    at      = (cur_q.op == OP_PWRITE) ? cur_q.position : ent.cur_pos;
    end_pos = sat_add(at, amt);
    contig  = ({1'b0, ent.bstart} + {1'b0, ent.bbytes}) == {1'b0, at};
    bb_ext  = sat_add(ent.bbytes, amt);
    has_bb  = ent.bbytes != '0;
    if (contig) begin
      bs_new = ent.bstart;
      bb_sum = bb_ext;
      hit    = bb_ext >= lim;
    end else begin
      bs_new = at;
      bb_sum = amt;
      hit    = amt >= lim;
    end

    ent_new = ent;
    a_vld   = 1'b0;
    b_vld   = 1'b0;
    a_res   = '{item_type: ITEM_BATCH, batch_offset: ent.bstart,
                batch_length: ent.bbytes, default: '0};
    b_res   = '0;
    s_res   = '{item_type: ITEM_STATUS, status: STAT_OK, last: 1'b1, default: '0};

    if (cur_q.op == OP_UNTRACKED || (cur_q.op != OP_OPEN && !ent.valid)) begin
      s_res.status = STAT_UNTRACKED;
    end else if (cur_q.op == OP_OPEN) begin
      if (ent.valid) begin
        s_res.status = STAT_OCCUPIED;
      end else begin
        ent_new = '{valid: 1'b1, size: cur_q.initial_size, default: '0};
      end
      s_res.file_size = ent_new.size;
    end else begin
      case (cur_q.op) inside
        OP_READ: ent_new.cur_pos = end_pos;
        OP_WRITE, OP_PWRITE: begin
          a_vld          = !contig && has_bb;
          b_vld          = hit;
          b_res          = '{item_type: ITEM_BATCH, batch_offset: bs_new,
                             batch_length: bb_sum, default: '0};
          ent_new.bstart = bs_new;
          ent_new.bbytes = hit ? '0 : bb_sum;
          if (cur_q.op == OP_WRITE) begin
            ent_new.cur_pos = end_pos;
          end
          if (ent.size < end_pos) begin
            ent_new.size = end_pos;
          end
        end
        OP_SEEK: ent_new.cur_pos = cur_q.position;
        OP_FSYNC, OP_FDSYNC: begin
          if (cfg_i.sync_laziness == LAZ_EAGER) begin
            a_vld          = has_bb;
            ent_new.bbytes = '0;
            b_vld          = 1'b1;
            b_res          = '{item_type: (cur_q.op == OP_FSYNC) ? ITEM_FSYNC : ITEM_FDSYNC,
                               wait_for_done: 1'b1, default: '0};
          end else if (cfg_i.sync_laziness != LAZ_IGNORE) begin
            if (cur_q.op == OP_FSYNC) begin
              ent_new.sync_def = 1'b1;
            end else begin
              ent_new.dsync_def = 1'b1;
            end
          end
        end
        OP_CLOSE: begin
          a_vld          = has_bb;
          ent_new.bbytes = '0;
          ent_new.valid  = 1'b0;
          b_vld          = (ent.sync_def || ent.dsync_def) &&
                           (cfg_i.sync_laziness == LAZ_WAIT ||
                            cfg_i.sync_laziness == LAZ_NOWAIT);
          b_res          = '{item_type: ITEM_CLOSE, data_only: !ent.sync_def,
                             wait_for_done: cfg_i.sync_laziness == LAZ_WAIT,
                             default: '0};
        end
        default: ;
      endcase
      s_res.file_size = ent_new.size;
    end
  end

  // pack results in emission order
  always_comb begin
    res_o.push = fire;
    res_o.res  = '0;
    if (a_vld && b_vld) begin
      res_o.cnt    = RES_BCNT_W'(3);
      res_o.res[0] = a_res;
      res_o.res[1] = b_res;
      res_o.res[2] = s_res;
    end else if (a_vld || b_vld) begin
      res_o.cnt    = RES_BCNT_W'(2);
      res_o.res[0] = a_vld ? a_res : b_res;
      res_o.res[1] = s_res;
    end else begin
      res_o.cnt    = RES_BCNT_W'(1);
      res_o.res[0] = s_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[rtl/pfwc_res_fifo.sv]
// Result queue: takes up to three results at once, delivers one per cycle while out_ready_i is high.
`default_nettype none

module pfwc_res_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pfwc_pkg::res_batch_t  wr_i,
  output logic                       space_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output pfwc_pkg::res_t             out_o
);
  import pfwc_pkg::*;

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic [RES_BCNT_W-1:0] push_cnt;
  logic                 pop;

  assign space_o     = cnt_q <= RES_CNT_W'(RES_DEPTH - RES_MAX);
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign push_cnt    = wr_i.push ? wr_i.cnt : '0;
  assign cnt_d       = cnt_q + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_cnt);
      rd_ptr_q <= rd_ptr_q + RES_PTR_W'(pop);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (RES_BCNT_W'(i) < push_cnt) begin
        mem_q[wr_ptr_q + RES_PTR_W'(i)] <= wr_i.res[i];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/per_file_write_coalescer_top.sv]
// Top level of the per-file write coalescer: config registers and datapath wiring.
`default_nettype none
`include "per_file_write_coalescer_top_macros.svh"

// Per-file write coalescer. Each item names a file slot; the block keeps a
// table of NUM_FILES entries (1024) and merges contiguous writes into one
// pending batch per file, emitting write-batch, sync and close-sync results
// followed by one status result (last = 1) per item. After reset the table
// is cleared entry by entry, during which in_ready_o stays low;
// configuration writes are taken at any time. Each item then passes
// through a registered table read and then a compute and write-back step;
// the back end waits in that step until the result queue has room for
// three results, so a stalled output stalls the back end. A two-entry
// command queue lets items be accepted meanwhile, and results leave a
// four-entry result queue at one per cycle while out_ready_i is high.
// batch_limit sits at byte 0x0 and sync_laziness at 0x8 of the
// 64-bit configuration port.
module per_file_write_coalescer_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel_i,
  input  wire logic                               penable_i,
  input  wire logic                               pwrite_i,
  input  wire logic [pfwc_pkg::PADDR_W-1:0]       paddr_i,
  input  wire logic [pfwc_pkg::PDATA_W-1:0]       pwdata_i,
  output logic      [pfwc_pkg::PDATA_W-1:0]       prdata_o,
  output logic                                    pready_o,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [pfwc_pkg::KIND_W-1:0]        kind_i,
  input  wire logic [pfwc_pkg::SLOT_W-1:0]        file_slot_i,
  input  wire logic [pfwc_pkg::AMT_W-1:0]         amount_i,
  input  wire logic [pfwc_pkg::POS_W-1:0]         position_i,
  input  wire logic [pfwc_pkg::POS_W-1:0]         initial_size_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [pfwc_pkg::TYPE_W-1:0]        item_type_o,
  output logic      [pfwc_pkg::POS_W-1:0]         batch_offset_o,
  output logic      [pfwc_pkg::POS_W-1:0]         batch_length_o,
  output logic                                    data_only_o,
  output logic                                    wait_for_done_o,
  output logic      [pfwc_pkg::STAT_W-1:0]        status_o,
  output logic      [pfwc_pkg::POS_W-1:0]         file_size_o,
  output logic                                    last_o
);
  import pfwc_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_we;
  logic       cmd_valid, cmd_pop, clearing, res_space;
  cmd_t       cmd;
  res_batch_t res_batch;
  res_t       res_head;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.batch_limit   <= BATCH_LIMIT_RST;
      cfg_q.sync_laziness <= LAZ_EAGER;
    end else if (cfg_we) begin
      unique case (paddr_i[REG_IDX_BIT])
        REG_BATCH_LIMIT:   cfg_q.batch_limit   <= pwdata_i[POS_W-1:0];
        REG_SYNC_LAZINESS: cfg_q.sync_laziness <= pwdata_i[LAZ_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[REG_IDX_BIT])
      REG_BATCH_LIMIT:   prdata_o = PDATA_W'(cfg_q.batch_limit);
      REG_SYNC_LAZINESS: prdata_o = PDATA_W'(cfg_q.sync_laziness);
    endcase
  end

  pfwc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .file_slot_i    (file_slot_i),
    .amount_i       (amount_i),
    .position_i     (position_i),
    .initial_size_i (initial_size_i),
    .hold_i         (clearing),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  pfwc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .res_space_i (res_space),
    .res_o       (res_batch)
  );

  pfwc_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (res_batch),
    .space_o     (res_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res_head)
  );

  assign item_type_o     = res_head.item_type;
  assign batch_offset_o  = res_head.batch_offset;
  assign batch_length_o  = res_head.batch_length;
  assign data_only_o     = res_head.data_only;
  assign wait_for_done_o = res_head.wait_for_done;
  assign status_o        = res_head.status;
  assign file_size_o     = res_head.file_size;
  assign last_o          = res_head.last;

  `PFWC_ASSERT_ALWAYS(a_no_accept_while_clearing, (clearing |-> !in_ready_o))
  `PFWC_ASSERT(a_last_on_status_only, (out_valid_o |-> (last_o == (item_type_o == ITEM_STATUS))))
  `PFWC_ASSERT(a_batch_nonempty, ((out_valid_o && item_type_o == ITEM_BATCH) |-> (batch_length_o != '0)))
  `PFWC_ASSERT(a_status_fields_clear, ((out_valid_o && item_type_o != ITEM_STATUS) |-> (status_o == STAT_OK && file_size_o == '0)))

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the per-file write coalescer: directed and random file ops.
`timescale 1ns / 100ps

module tb_top;
  import pfwc_pkg::*;

  localparam int IDLE_PCT    = 13;
  localparam int HOLD_AT     = 45;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE      = 16;
  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(NUM_FILES - 1);
  localparam logic [KIND_W-1:0]  KIND_MAX = '1;
  localparam logic [AMT_W-1:0]   AMT_MAX  = '1;
  localparam logic [PADDR_W-1:0] ADDR_BATCH_LIMIT   = PADDR_W'(REG_BATCH_LIMIT) << REG_IDX_BIT;
  localparam logic [PADDR_W-1:0] ADDR_SYNC_LAZINESS = PADDR_W'(REG_SYNC_LAZINESS) << REG_IDX_BIT;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [AMT_W-1:0]  amount;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  isize;
  } file_op_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] kind      = '0;
  logic [SLOT_W-1:0] file_slot = '0;
  logic [AMT_W-1:0]  amount    = '0;
  logic [POS_W-1:0]  position  = '0;
  logic [POS_W-1:0]  init_size = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [TYPE_W-1:0] item_type;
  logic [POS_W-1:0]  batch_offset;
  logic [POS_W-1:0]  batch_length;
  logic              data_only;
  logic              wait_for_done;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  file_size;
  logic              last;

  file_op_t op_queue[$];
  res_t     pending_results[$];

  // predicted file table and registers
  logic             f_valid  [NUM_FILES];
  logic [POS_W-1:0] f_pos    [NUM_FILES];
  logic [POS_W-1:0] f_size   [NUM_FILES];
  logic [POS_W-1:0] f_bstart [NUM_FILES];
  logic [POS_W-1:0] f_bbytes [NUM_FILES];
  logic             f_sdef   [NUM_FILES];
  logic             f_dsdef  [NUM_FILES];
  logic [POS_W-1:0] lim_cfg = BATCH_LIMIT_RST;
  logic [LAZ_W-1:0] laz_cfg = LAZ_EAGER;

  // generator-side view of which slots are open
  bit               gen_open    [NUM_FILES];
  logic [POS_W-1:0] gen_pw_next [NUM_FILES];
  int unsigned      slot_pool [5];

  int n_offered  = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_cfg_done = 0;
  int n_batches  = 0;
  int n_syncs    = 0;
  int n_closes   = 0;
  int mismatches = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  wire quiet_tx = (n_offered >= 90) && (n_offered < 140);
  wire quiet_rx = (n_results >= 200) && (n_results < 280);

  always #4 clk = ~clk;

  per_file_write_coalescer_top DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .pready_o       (pready),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .file_slot_i    (file_slot),
    .amount_i       (amount),
    .position_i     (position),
    .initial_size_i (init_size),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .item_type_o    (item_type),
    .batch_offset_o (batch_offset),
    .batch_length_o (batch_length),
    .data_only_o    (data_only),
    .wait_for_done_o(wait_for_done),
    .status_o       (status),
    .file_size_o    (file_size),
    .last_o         (last)
  );

  function automatic logic [POS_W-1:0] clamp_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
    logic [POS_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[POS_W] ? POS_MAX : t[POS_W-1:0];
  endfunction

  function automatic void expect_res(input logic [TYPE_W-1:0] typ,
                                     input logic [POS_W-1:0] off, input logic [POS_W-1:0] len,
                                     input logic donly, input logic wfd,
                                     input logic [STAT_W-1:0] st,
                                     input logic [POS_W-1:0] size, input logic lst);
    res_t r;
    r.item_type     = typ;
    r.batch_offset  = off;
    r.batch_length  = len;
    r.data_only     = donly;
    r.wait_for_done = wfd;
    r.status        = st;
    r.file_size     = size;
    r.last          = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void flush_pending(input int unsigned s);
    if (f_bbytes[s] != '0) begin
      expect_res(ITEM_BATCH, f_bstart[s], f_bbytes[s], 1'b0, 1'b0, STAT_OK, '0, 1'b0);
      f_bbytes[s] = '0;
    end
  endfunction

  function automatic void merge_write(input int unsigned s, input logic [POS_W-1:0] at,
                                      input logic [AMT_W-1:0] amt, input logic move);
    logic [POS_W-1:0] lim;
    logic [POS_W-1:0] stop;
    lim = (lim_cfg == '0) ? POS_W'(1) : lim_cfg;
    if ({1'b0, f_bstart[s]} + {1'b0, f_bbytes[s]} != {1'b0, at}) begin
      flush_pending(s);
      f_bstart[s] = at;
    end
    stop = clamp_add(at, POS_W'(amt));
    if (move) f_pos[s] = stop;
    if (f_size[s] < stop) f_size[s] = stop;
    f_bbytes[s] = clamp_add(f_bbytes[s], POS_W'(amt));
    if (f_bbytes[s] >= lim) flush_pending(s);
  endfunction

  function automatic void predict_file_op(input file_op_t op);
    int unsigned s;
    s = op.slot;
    if (op.kind == KIND_OPEN) begin
      if (f_valid[s]) begin
        expect_res(ITEM_STATUS, '0, '0, 1'b0, 1'b0, STAT_OCCUPIED, f_size[s], 1'b1);
      end else begin
        f_valid[s]  = 1'b1;
        f_pos[s]    = '0;
        f_size[s]   = op.isize;
        f_bstart[s] = '0;
        f_bbytes[s] = '0;
        f_sdef[s]   = 1'b0;
        f_dsdef[s]  = 1'b0;
        expect_res(ITEM_STATUS, '0, '0, 1'b0, 1'b0, STAT_OK, op.isize, 1'b1);
      end
      return;
    end
    if (!f_valid[s]) begin
      expect_res(ITEM_STATUS, '0, '0, 1'b0, 1'b0, STAT_UNTRACKED, '0, 1'b1);
      return;
    end
    case (op.kind)
      KIND_READ:   f_pos[s] = clamp_add(f_pos[s], POS_W'(op.amount));
      KIND_WRITE:  merge_write(s, f_pos[s], op.amount, 1'b1);
      KIND_PWRITE: merge_write(s, op.position, op.amount, 1'b0);
      KIND_SEEK:   f_pos[s] = op.position;
      KIND_FSYNC, KIND_FDSYNC: begin
        if (laz_cfg == LAZ_EAGER) begin
          flush_pending(s);
          expect_res((op.kind == KIND_FSYNC) ? ITEM_FSYNC : ITEM_FDSYNC,
                     '0, '0, 1'b0, 1'b1, STAT_OK, '0, 1'b0);
        end else if (laz_cfg != LAZ_IGNORE) begin
          if (op.kind == KIND_FSYNC) f_sdef[s] = 1'b1;
          else f_dsdef[s] = 1'b1;
        end
      end
      KIND_CLOSE: begin
        flush_pending(s);
        if ((f_sdef[s] || f_dsdef[s]) && (laz_cfg == LAZ_WAIT || laz_cfg == LAZ_NOWAIT))
          expect_res(ITEM_CLOSE, '0, '0, !f_sdef[s], laz_cfg == LAZ_WAIT, STAT_OK, '0, 1'b0);
        f_valid[s] = 1'b0;
      end
      default: ;
    endcase
    expect_res(ITEM_STATUS, '0, '0, 1'b0, 1'b0, STAT_OK, f_size[s], 1'b1);
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return AMT_W'($urandom_range(1, 3000));
    else if (r < 85) return '0;
    else if (r < 93) return AMT_W'($urandom);
    else return AMT_MAX;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return POS_W'($urandom_range(0, 20000));
    else if (r < 60) return '0;
    else if (r < 80) return POS_MAX - POS_W'($urandom_range(0, 5000));
    else return POS_W'({$urandom, $urandom});
  endfunction

  function automatic void push_item(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] s,
                                    input logic [AMT_W-1:0] amt, input logic [POS_W-1:0] pos,
                                    input logic [POS_W-1:0] isz);
    file_op_t op;
    op.kind     = k;
    op.slot     = s;
    op.amount   = amt;
    op.position = pos;
    op.isize    = isz;
    if (k == KIND_OPEN && !gen_open[s]) begin
      gen_open[s]    = 1'b1;
      gen_pw_next[s] = '0;
    end else if (k == KIND_CLOSE) begin
      gen_open[s] = 1'b0;
    end else if (k == KIND_PWRITE && gen_open[s]) begin
      gen_pw_next[s] = clamp_add(pos, POS_W'(amt));
    end
    op_queue.push_back(op);
  endfunction

  task automatic wait_idle();
    while (op_queue.size() != 0 || n_accepted != n_offered || pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    int target;
    target = n_cfg_done + 1;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    while (n_cfg_done < target) @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [POS_W-1:0] lim, input logic [LAZ_W-1:0] laz,
                           input bit dirty, input int n_rand);
    logic [PDATA_W-1:0] word;
    logic [KIND_W-1:0]  k;
    logic [POS_W-1:0]   pos;
    int unsigned        s;
    int unsigned        r;
    wait_idle();
    word = dirty ? {$urandom, $urandom} : '0;
    word[POS_W-1:0] = lim;
    write_reg(ADDR_BATCH_LIMIT, word);
    word = dirty ? {$urandom, $urandom} : '0;
    word[LAZ_W-1:0] = laz;
    write_reg(ADDR_SYNC_LAZINESS, word);

    slot_pool[0] = 0;
    slot_pool[1] = 32'(SLOT_LAST);
    for (int i = 2; i < 5; i++) slot_pool[i] = $urandom_range(0, SLOT_LAST);

    // deferred sync paths: data-only close, then full close
    s = slot_pool[2];
    if (gen_open[s]) push_item(KIND_CLOSE, SLOT_W'(s), '0, '0, '0);
    push_item(KIND_OPEN, SLOT_W'(s), '0, '0, POS_W'($urandom_range(0, 5000)));
    push_item(KIND_WRITE, SLOT_W'(s), 64, '0, '0);
    push_item(KIND_FDSYNC, SLOT_W'(s), '0, '0, '0);
    push_item(KIND_CLOSE, SLOT_W'(s), '0, '0, '0);
    push_item(KIND_OPEN, SLOT_W'(s), '0, '0, '0);
    push_item(KIND_FSYNC, SLOT_W'(s), '0, '0, '0);
    push_item(KIND_FDSYNC, SLOT_W'(s), '0, '0, '0);
    push_item(KIND_WRITE, SLOT_W'(s), 10, '0, '0);
    push_item(KIND_CLOSE, SLOT_W'(s), '0, '0, '0);

    repeat (n_rand) begin
      if ($urandom_range(0, 99) < 8) begin
        push_item(KIND_W'($urandom_range(0, KIND_MAX)), SLOT_W'($urandom_range(0, SLOT_LAST)),
                  pick_amount(), pick_position(), pick_position());
      end else begin
        s = slot_pool[$urandom_range(0, 4)];
        if (!gen_open[s]) begin
          k = ($urandom_range(0, 99) < 85) ? KIND_OPEN
                                           : KIND_W'($urandom_range(KIND_READ, KIND_MAX));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 35) k = KIND_WRITE;
          else if (r < 50) k = KIND_PWRITE;
          else if (r < 58) k = KIND_READ;
          else if (r < 66) k = KIND_SEEK;
          else if (r < 73) k = KIND_FSYNC;
          else if (r < 80) k = KIND_FDSYNC;
          else if (r < 88) k = KIND_CLOSE;
          else if (r < 93) k = KIND_QUERY;
          else if (r < 96) k = KIND_OPEN;
          else k = KIND_W'($urandom_range(KIND_QUERY + 1, KIND_MAX));
        end
        pos = (k == KIND_PWRITE && $urandom_range(0, 9) < 7) ? gen_pw_next[s] : pick_position();
        push_item(k, SLOT_W'(s), pick_amount(), pos, pick_position());
      end
    end
  endtask

  // item driver
  always @(negedge clk) begin : feed
    file_op_t op;
    if (rst_n && n_accepted == n_offered) begin
      if (op_queue.size() != 0 && (quiet_tx || $urandom_range(0, 99) >= IDLE_PCT)) begin
        op = op_queue.pop_front();
        kind      <= op.kind;
        file_slot <= op.slot;
        amount    <= op.amount;
        position  <= op.position;
        init_size <= op.isize;
        in_valid  <= 1'b1;
        n_offered = n_offered + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_rx || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check
    file_op_t op;
    res_t     got;
    res_t     want;
    logic     bad;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[REG_IDX_BIT] == REG_SYNC_LAZINESS) laz_cfg = pwdata[LAZ_W-1:0];
        else lim_cfg = pwdata[POS_W-1:0];
        n_cfg_done = n_cfg_done + 1;
      end
      if (out_valid && out_ready) begin
        got.item_type     = item_type;
        got.batch_offset  = batch_offset;
        got.batch_length  = batch_length;
        got.data_only     = data_only;
        got.wait_for_done = wait_for_done;
        got.status        = status;
        got.file_size     = file_size;
        got.last          = last;
        if (got.item_type == ITEM_BATCH) n_batches++;
        if (got.item_type == ITEM_FSYNC || got.item_type == ITEM_FDSYNC) n_syncs++;
        if (got.item_type == ITEM_CLOSE) n_closes++;
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result %0d: type=%0d off=%h len=%h st=%0d size=%h last=%b",
                     n_results, got.item_type, got.batch_offset, got.batch_length,
                     got.status, got.file_size, got.last);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          bad = (got.item_type !== want.item_type) || (got.batch_offset !== want.batch_offset) ||
                (got.batch_length !== want.batch_length) || (got.data_only !== want.data_only) ||
                (got.wait_for_done !== want.wait_for_done) || (got.status !== want.status) ||
                (got.file_size !== want.file_size) || (got.last !== want.last);
          if (bad) begin
            if (mismatches < 10) begin
              $display("mismatch at result %0d", n_results);
              $display("  exp type=%0d off=%h len=%h donly=%b wait=%b st=%0d size=%h last=%b",
                       want.item_type, want.batch_offset, want.batch_length, want.data_only,
                       want.wait_for_done, want.status, want.file_size, want.last);
              $display("  got type=%0d off=%h len=%h donly=%b wait=%b st=%0d size=%h last=%b",
                       got.item_type, got.batch_offset, got.batch_length, got.data_only,
                       got.wait_for_done, got.status, got.file_size, got.last);
            end
            mismatches++;
          end
        end
        n_results++;
      end
      if (in_valid && in_ready) begin
        op.kind     = kind;
        op.slot     = file_slot;
        op.amount   = amount;
        op.position = position;
        op.isize    = init_size;
        predict_file_op(op);
        n_accepted = n_accepted + 1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    foreach (f_valid[i]) f_valid[i] = 1'b0;
    foreach (gen_open[i]) gen_open[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed part at reset configuration
    push_item(KIND_QUERY, 5, '0, '0, '0);
    push_item(KIND_OPEN, 0, '0, '0, '0);
    push_item(KIND_OPEN, 0, AMT_MAX, POS_MAX, POS_MAX);
    push_item(KIND_OPEN, SLOT_LAST, AMT_MAX, POS_MAX, POS_MAX);
    push_item(KIND_WRITE, 0, 100, '0, '0);
    push_item(KIND_WRITE, 0, 50, '0, '0);
    push_item(KIND_PWRITE, 0, 10, 500, '0);
    push_item(KIND_PWRITE, 0, 20, 510, '0);
    push_item(KIND_READ, 0, 7, '0, '0);
    push_item(KIND_SEEK, 0, '0, POS_MAX - 3, '0);
    push_item(KIND_WRITE, 0, AMT_MAX, '0, '0);
    push_item(KIND_WRITE, 0, 5, '0, '0);
    push_item(KIND_READ, 0, AMT_MAX, '0, '0);
    push_item(KIND_FSYNC, 0, '0, '0, '0);
    push_item(KIND_FDSYNC, 0, '0, '0, '0);
    push_item(KIND_PWRITE, SLOT_LAST, '0, POS_MAX, '0);
    push_item(KIND_WRITE, SLOT_LAST, 2000000, '0, '0);
    push_item(KIND_WRITE, SLOT_LAST, 1000, '0, '0);
    push_item(KIND_FSYNC, SLOT_LAST, '0, '0, '0);
    push_item(KIND_MAX, SLOT_LAST, AMT_MAX, POS_MAX, POS_MAX);
    push_item(KIND_W'(KIND_QUERY + 1), 0, '0, '0, '0);
    push_item(KIND_CLOSE, 0, '0, '0, '0);
    push_item(KIND_CLOSE, 0, '0, '0, '0);
    push_item(KIND_CLOSE, SLOT_LAST, '0, '0, '0);

    run_phase(POS_W'(1), LAZ_WAIT, 1'b0, 25);
    run_phase('0, LAZ_NOWAIT, 1'b0, 25);
    run_phase(POS_MAX, LAZ_IGNORE, 1'b1, 25);
    run_phase(POS_W'(4096), LAZ_EAGER, 1'b1, 25);
    run_phase(POS_W'($urandom_range(64, 20000)), LAZ_W'($urandom_range(0, 3)), 1'b1, 25);
    wait_idle();

    $display("summary: %0d items, %0d results (%0d write batches, %0d sync requests, %0d close syncs)",
             n_accepted, n_results, n_batches, n_syncs, n_closes);
    $display("summary: 6 register settings incl. limit 0/1/max and all laziness levels, %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/pfwc_pkg.sv
rtl/pfwc_ram.sv
rtl/pfwc_front.sv
rtl/pfwc_back.sv
rtl/pfwc_res_fifo.sv
rtl/per_file_write_coalescer_top.sv
bench/tb_top.sv
